/* src/tcce_pkg.sv */
package tcce_pkg;

    localparam int DEF_MAX_COLUMNS = 128;
    localparam int DEF_MAX_ROWS    = 64;

    localparam int POS_W       = 13;
    localparam int CHAR_W      = 8;
    localparam int COORD_W     = 8;
    localparam int ATTR_W      = 8;
    localparam int COLS_CFG_W  = 8;
    localparam int ROWS_CFG_W  = 7;
    localparam int MODE_W      = 2;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 8;
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 48;
    localparam int TAB_STOP    = 8;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [MODE_W-1:0] MODE_PUT    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_LOCATE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_SET    = 2'd2;

    localparam logic [CFG_INDEX_W-1:0] REG_COLUMNS   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_ROWS      = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_ATTRIBUTE = 2'd2;

    localparam logic [COLS_CFG_W-1:0] COLUMNS_RESET   = 8'd80;
    localparam logic [ROWS_CFG_W-1:0] ROWS_RESET      = 7'd25;
    localparam logic [ATTR_W-1:0]     ATTRIBUTE_RESET = 8'd15;

    localparam logic [CHAR_W-1:0] CH_BELL      = 8'd7;
    localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
    localparam logic [CHAR_W-1:0] CH_TAB       = 8'd9;
    localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
    localparam logic [CHAR_W-1:0] CH_VTAB      = 8'd11;
    localparam logic [CHAR_W-1:0] CH_FORMFEED  = 8'd12;
    localparam logic [CHAR_W-1:0] CH_RETURN    = 8'd13;

    typedef enum logic [3:0] {
        OP_PRINT,
        OP_NEWLINE,
        OP_BACKSPACE,
        OP_TAB,
        OP_RETURN,
        OP_VTAB,
        OP_HOME,
        OP_BELL,
        OP_LOCATE,
        OP_SETPOS,
        OP_QUERY
    } op_t;

    typedef struct packed {
        op_t                op;
        logic [CHAR_W-1:0]  character;
        logic [COORD_W-1:0] column_x;
        logic [COORD_W-1:0] row_y;
        logic [POS_W-1:0]   position;
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_DIV,
        ST_EXEC,
        ST_MUL,
        ST_ADD,
        ST_WRAP
    } state_t;

endpackage

/* src/tcce_front.sv */
module tcce_front
    import tcce_pkg::*;
(
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_TDATA_W-1:0] s_tdata,  // character, column_x, row_y, position, zero pad
    input  logic [MODE_W-1:0]     s_tuser,  // mode
    output logic                  push_valid,
    input  logic                  push_ready,
    output cmd_t                  push_cmd
);

    op_t op;

    always_comb begin
        unique case (s_tuser)
            MODE_PUT: begin
                unique case (s_tdata[CHAR_W-1:0])
                    CH_NEWLINE:   op = OP_NEWLINE;
                    CH_BACKSPACE: op = OP_BACKSPACE;
                    CH_TAB:       op = OP_TAB;
                    CH_RETURN:    op = OP_RETURN;
                    CH_VTAB:      op = OP_VTAB;
                    CH_FORMFEED:  op = OP_HOME;
                    CH_BELL:      op = OP_BELL;
                    default:      op = OP_PRINT;
                endcase
            end
            MODE_LOCATE: op = OP_LOCATE;
            MODE_SET:    op = OP_SETPOS;
            default:     op = OP_QUERY;
        endcase
    end

    assign push_cmd.op        = op;
    assign push_cmd.character = s_tdata[7:0];
    assign push_cmd.column_x  = s_tdata[15:8];
    assign push_cmd.row_y     = s_tdata[23:16];
    assign push_cmd.position  = s_tdata[36:24];

    assign push_valid = s_tvalid;
    assign s_tready   = push_ready;

endmodule

/* src/tcce_queue.sv */
module tcce_queue
    import tcce_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic push_valid,
    output logic push_ready,
    input  cmd_t push_cmd,
    output logic pop_valid,
    input  logic pop_ready,
    output cmd_t pop_cmd
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    cmd_t             slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign push_ready = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_cmd    = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

/* src/tcce_back.sv */
module tcce_back
    import tcce_pkg::*;
#(
    parameter int MAX_COLUMNS = DEF_MAX_COLUMNS,
    parameter int MAX_ROWS    = DEF_MAX_ROWS
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   cmd_valid,
    output logic                   cmd_ready,
    input  cmd_t                   cmd,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,
    output logic                   m_tuser
);

    localparam int CW    = $clog2(MAX_COLUMNS + 1);
    localparam int RW    = $clog2(MAX_ROWS + 1);
    localparam int SW    = CW + RW;
    localparam int PW    = ((SW > POS_W) ? SW : POS_W) + 1;
    localparam int CNT_W = $clog2(PW);

    // Configuration and derived geometry.
    logic [COLS_CFG_W-1:0] columns_reg;
    logic [ROWS_CFG_W-1:0] rows_reg;
    logic [ATTR_W-1:0]     attribute_reg;
    logic [CW-1:0]         cols_eff;
    logic [RW-1:0]         rows_eff;
    logic [SW-1:0]         size_reg;
    logic [PW-1:0]         size_w, cols_w, rows_w, last_w, wrap_w;

    // Sequencer state and datapath.
    state_t             state_reg, state_next;
    op_t                op_reg, op_next;
    logic [CHAR_W-1:0]  char_reg, char_next;
    logic [COORD_W-1:0] x_reg, x_next;
    logic [COORD_W-1:0] y_reg, y_next;
    logic [POS_W-1:0]   setp_reg, setp_next;
    logic [POS_W-1:0]   cursor_reg, cursor_next;
    logic [PW-1:0]      pos_reg, pos_next;
    logic [PW-1:0]      quo_reg, quo_next;
    logic [CW-1:0]      rem_reg, rem_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [RW-1:0]      mul_a_reg, mul_a_next;
    logic [CW-1:0]      base_reg, base_next;
    logic [SW-1:0]      prod_reg, prod_next;

    // Result register.
    logic               m_valid_reg, m_valid_next;
    logic               m_wv_reg, m_wv_next;
    logic [POS_W-1:0]   m_waddr_reg, m_waddr_next;
    logic [CHAR_W-1:0]  m_wchar_reg, m_wchar_next;
    logic [ATTR_W-1:0]  m_wattr_reg, m_wattr_next;
    logic               m_scroll_reg, m_scroll_next;
    logic [POS_W-1:0]   m_cursor_reg, m_cursor_next;

    logic [PW-1:0]      cursor_w, clamp_pos, tab_pos, fin_pos, x_w, y_w, setp_w;
    logic [CW:0]        rem_shift;
    logic               is_put;

    assign cfg_ready = 1'b1;

    always_comb begin
        if (columns_reg == '0) begin
            cols_eff = CW'(1);
        end else if ({1'b0, columns_reg} > 9'(MAX_COLUMNS)) begin
            cols_eff = CW'(MAX_COLUMNS);
        end else begin
            cols_eff = CW'(columns_reg);
        end
        if (rows_reg == '0) begin
            rows_eff = RW'(1);
        end else if ({1'b0, rows_reg} > 8'(MAX_ROWS)) begin
            rows_eff = RW'(MAX_ROWS);
        end else begin
            rows_eff = RW'(rows_reg);
        end
    end

    assign size_w   = PW'(size_reg);
    assign cols_w   = PW'(cols_eff);
    assign rows_w   = PW'(rows_eff);
    assign last_w   = size_w - PW'(1);
    assign wrap_w   = size_w - cols_w;
    assign cursor_w = PW'(cursor_reg);
    assign x_w      = PW'(x_reg);
    assign y_w      = PW'(y_reg);
    assign setp_w   = PW'(setp_reg);

    // A cursor left past the end by a smaller screen is pulled back to the last cell first.
    assign clamp_pos = (cursor_w >= size_w) ? last_w : cursor_w;
    assign rem_shift = {rem_reg, quo_reg[PW-1]};

    always_comb begin
        tab_pos = (pos_reg + PW'(TAB_STOP)) & ~PW'(TAB_STOP - 1);
        if (tab_pos >= size_w) begin
            tab_pos = last_w;
        end
    end

    assign is_put = (op_reg != OP_LOCATE) && (op_reg != OP_SETPOS) && (op_reg != OP_QUERY);
    assign fin_pos = (is_put && (pos_reg >= size_w)) ? wrap_w : pos_reg;

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (cmd_valid && cmd_ready) begin
                    state_next = ST_PREP;
                end
            end
            ST_PREP: begin
                unique case (op_reg)
                    OP_NEWLINE, OP_RETURN: state_next = ST_DIV;
                    OP_LOCATE:             state_next = ST_MUL;
                    OP_SETPOS, OP_QUERY:   state_next = ST_WRAP;
                    default:               state_next = ST_EXEC;
                endcase
            end
            ST_DIV: begin
                if (cnt_reg == '0) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                state_next = (op_reg == OP_NEWLINE) ? ST_MUL : ST_WRAP;
            end
            ST_MUL:  state_next = ST_ADD;
            ST_ADD:  state_next = ST_WRAP;
            ST_WRAP: state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    assign cmd_ready = (state_reg == ST_IDLE) && !m_valid_reg;

    // Datapath and outputs.
    always_comb begin
        op_next       = op_reg;
        char_next     = char_reg;
        x_next        = x_reg;
        y_next        = y_reg;
        setp_next     = setp_reg;
        cursor_next   = cursor_reg;
        pos_next      = pos_reg;
        quo_next      = quo_reg;
        rem_next      = rem_reg;
        cnt_next      = cnt_reg;
        mul_a_next    = mul_a_reg;
        base_next     = base_reg;
        prod_next     = prod_reg;
        m_valid_next  = m_valid_reg;
        m_wv_next     = m_wv_reg;
        m_waddr_next  = m_waddr_reg;
        m_wchar_next  = m_wchar_reg;
        m_wattr_next  = m_wattr_reg;
        m_scroll_next = m_scroll_reg;
        m_cursor_next = m_cursor_reg;

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (cmd_valid && cmd_ready) begin
                    op_next      = cmd.op;
                    char_next    = cmd.character;
                    x_next       = cmd.column_x;
                    y_next       = cmd.row_y;
                    setp_next    = cmd.position;
                    m_wv_next    = 1'b0;
                    m_waddr_next = '0;
                    m_wchar_next = '0;
                    m_wattr_next = '0;
                end
            end
            ST_PREP: begin
                unique case (op_reg)
                    OP_LOCATE: begin
                        base_next  = (x_w >= cols_w) ? CW'(cols_eff - CW'(1)) : CW'(x_reg);
                        mul_a_next = (y_w >= rows_w) ? RW'(rows_eff - RW'(1)) : RW'(y_reg);
                    end
                    OP_SETPOS: pos_next = (setp_w >= size_w) ? last_w : setp_w;
                    OP_QUERY:  pos_next = cursor_w;
                    default: begin
                        pos_next = clamp_pos;
                        quo_next = clamp_pos;
                        rem_next = '0;
                        cnt_next = CNT_W'(PW - 1);
                    end
                endcase
            end
            ST_DIV: begin
                // One quotient bit per cycle, restoring division by the column count.
                if (rem_shift >= {1'b0, cols_eff}) begin
                    rem_next = CW'(rem_shift - {1'b0, cols_eff});
                    quo_next = {quo_reg[PW-2:0], 1'b1};
                end else begin
                    rem_next = rem_shift[CW-1:0];
                    quo_next = {quo_reg[PW-2:0], 1'b0};
                end
                cnt_next = cnt_reg - CNT_W'(1);
            end
            ST_EXEC: begin
                unique case (op_reg)
                    OP_PRINT: begin
                        m_wv_next    = 1'b1;
                        m_waddr_next = pos_reg[POS_W-1:0];
                        m_wchar_next = char_reg;
                        m_wattr_next = attribute_reg;
                        pos_next     = pos_reg + PW'(1);
                    end
                    OP_NEWLINE: begin
                        // The cursor is inside the screen, so the next line index fits the row width.
                        mul_a_next = quo_reg[RW-1:0] + RW'(1);
                        base_next  = '0;
                    end
                    OP_BACKSPACE: begin
                        if (pos_reg != '0) begin
                            pos_next = pos_reg - PW'(1);
                        end
                    end
                    OP_TAB:    pos_next = tab_pos;
                    OP_RETURN: pos_next = pos_reg - PW'(rem_reg);
                    OP_VTAB: begin
                        if ((pos_reg + cols_w) < size_w) begin
                            pos_next = pos_reg + cols_w;
                        end
                    end
                    OP_HOME: pos_next = '0;
                    default: pos_next = pos_reg;
                endcase
            end
            ST_MUL: begin
                prod_next = SW'(mul_a_reg) * SW'(cols_eff);
            end
            ST_ADD: begin
                pos_next = PW'(base_reg) + PW'(prod_reg);
            end
            ST_WRAP: begin
                m_valid_next  = 1'b1;
                m_scroll_next = is_put && (pos_reg >= size_w);
                m_cursor_next = fin_pos[POS_W-1:0];
                cursor_next   = fin_pos[POS_W-1:0];
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            columns_reg   <= COLUMNS_RESET;
            rows_reg      <= ROWS_RESET;
            attribute_reg <= ATTRIBUTE_RESET;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_COLUMNS:   columns_reg   <= cfg_data[COLS_CFG_W-1:0];
                REG_ROWS:      rows_reg      <= cfg_data[ROWS_CFG_W-1:0];
                REG_ATTRIBUTE: attribute_reg <= cfg_data[ATTR_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cursor_reg  <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cursor_reg  <= cursor_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        size_reg     <= SW'(cols_eff) * SW'(rows_eff);
        op_reg       <= op_next;
        char_reg     <= char_next;
        x_reg        <= x_next;
        y_reg        <= y_next;
        setp_reg     <= setp_next;
        pos_reg      <= pos_next;
        quo_reg      <= quo_next;
        rem_reg      <= rem_next;
        cnt_reg      <= cnt_next;
        mul_a_reg    <= mul_a_next;
        base_reg     <= base_next;
        prod_reg     <= prod_next;
        m_wv_reg     <= m_wv_next;
        m_waddr_reg  <= m_waddr_next;
        m_wchar_reg  <= m_wchar_next;
        m_wattr_reg  <= m_wattr_next;
        m_scroll_reg <= m_scroll_next;
        m_cursor_reg <= m_cursor_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_wv_reg;
    assign m_tdata  = OUT_TDATA_W'({m_cursor_reg, m_scroll_reg, m_wattr_reg,
                                    m_wchar_reg, m_waddr_reg});

endmodule

/* src/text_console_cursor_engine.sv */
// Cursor engine for a text screen of columns by rows cells. Each beat on the s_ side is a
// put-character, locate, set-position or cursor query request; each gives exactly one beat
// on the m_ side with an optional cell write, a scroll request and the new cursor. Requests
// are handled one at a time by a sequencer behind a two-entry queue, so up to two further
// beats are taken while one is in work or its result waits. Most requests pass prepare,
// execute and wrap; a locate passes prepare, multiply, add and wrap, a set-position or
// query prepare and wrap. Newline and carriage return need the cursor divided by the
// column count, done by a bit-serial divider of PW = max(CW+RW, 13) + 1 steps (CW and
// RW being the bit widths of MAX_COLUMNS and MAX_ROWS) ahead of execute. Configuration
// writes are always accepted and must only be issued while no request is outstanding.
module text_console_cursor_engine
    import tcce_pkg::*;
#(
    parameter int MAX_COLUMNS = DEF_MAX_COLUMNS,
    parameter int MAX_ROWS    = DEF_MAX_ROWS
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,  // character, column_x, row_y, position, zero pad
    input  logic [MODE_W-1:0]      s_tuser,  // mode
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,  // write_address, write_character,
                                             // write_attribute, scroll, cursor, zero pad
    output logic                   m_tuser   // write_valid
);

    logic push_valid, push_ready, pop_valid, pop_ready;
    cmd_t push_cmd, pop_cmd;

    tcce_front u_front (
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd)
    );

    tcce_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_cmd    (pop_cmd)
    );

    tcce_back #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .MAX_ROWS    (MAX_ROWS)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd_valid (pop_valid),
        .cmd_ready (pop_ready),
        .cmd       (pop_cmd),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

/* tb/sv/testbench.sv */
module testbench;
    import tcce_pkg::*;

    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
    localparam int HOLD_CYCLES = 300;
    localparam int IDLE_PERCENT = 11;

    typedef struct {
        logic [MODE_W-1:0]  mode;
        logic [CHAR_W-1:0]  character;
        logic [COORD_W-1:0] column_x;
        logic [COORD_W-1:0] row_y;
        logic [POS_W-1:0]   position;
    } request_t;

    typedef struct {
        logic              write_valid;
        logic [POS_W-1:0]  write_address;
        logic [CHAR_W-1:0] write_character;
        logic [ATTR_W-1:0] write_attribute;
        logic              scroll;
        logic [POS_W-1:0]  cursor;
    } cell_result_t;

    logic                   aclk;
    logic                   aresetn   = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata   = '0;
    logic [MODE_W-1:0]      s_tuser   = '0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   m_tuser;

    // Shadow copy of the block's registers and cursor.
    logic [COLS_CFG_W-1:0] cols_shadow   = COLUMNS_RESET;
    logic [ROWS_CFG_W-1:0] rows_shadow   = ROWS_RESET;
    logic [ATTR_W-1:0]     attr_shadow   = ATTRIBUTE_RESET;
    logic [POS_W-1:0]      cursor_shadow = '0;

    request_t     pending_reqs[$];
    cell_result_t expected_cells[$];
    request_t     offered_req;
    int           queued_count   = 0;
    int           accepted_count = 0;
    int           result_count   = 0;
    int           fail_count     = 0;
    int           write_beats    = 0;
    bit           idle_enable    = 1'b1;
    int           hold_requests  = 0;
    int           hold_served    = 0;
    int           rx_hold_left   = 0;

    text_console_cursor_engine i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    function automatic int unsigned eff_columns();
        int unsigned c;
        c = cols_shadow;
        if (c == 0) c = 1;
        if (c > DEF_MAX_COLUMNS) c = DEF_MAX_COLUMNS;
        return c;
    endfunction

    function automatic int unsigned eff_rows();
        int unsigned r;
        r = rows_shadow;
        if (r == 0) r = 1;
        if (r > DEF_MAX_ROWS) r = DEF_MAX_ROWS;
        return r;
    endfunction

    // Computes the result beat of one request and advances the shadow cursor.
    function automatic cell_result_t predict_cell(request_t rq);
        int unsigned cols, rws, size, pos, x, y;
        cell_result_t res;
        cols = eff_columns();
        rws  = eff_rows();
        size = cols * rws;
        pos  = cursor_shadow;
        res  = '{default: '0};
        case (rq.mode)
            MODE_PUT: begin
                if (pos >= size) pos = size - 1;
                case (rq.character)
                    CH_NEWLINE:   pos = (pos / cols + 1) * cols;
                    CH_BACKSPACE: if (pos > 0) pos = pos - 1;
                    CH_TAB: begin
                        pos = (pos + TAB_STOP) & ~(TAB_STOP - 1);
                        if (pos >= size) pos = size - 1;
                    end
                    CH_RETURN:    pos = pos - pos % cols;
                    CH_VTAB:      if (pos + cols < size) pos = pos + cols;
                    CH_FORMFEED:  pos = 0;
                    CH_BELL:      ;
                    default: begin
                        res.write_valid     = 1'b1;
                        res.write_address   = POS_W'(pos);
                        res.write_character = rq.character;
                        res.write_attribute = attr_shadow;
                        pos = pos + 1;
                    end
                endcase
                // Running off the end scrolls and lands on the start of the last line.
                if (pos >= size) begin
                    res.scroll = 1'b1;
                    pos = size - cols;
                end
            end
            MODE_LOCATE: begin
                x = rq.column_x;
                y = rq.row_y;
                if (x >= cols) x = cols - 1;
                if (y >= rws) y = rws - 1;
                pos = x + y * cols;
            end
            MODE_SET: pos = (rq.position >= size) ? size - 1 : rq.position;
            default: ;
        endcase
        cursor_shadow = POS_W'(pos);
        res.cursor = cursor_shadow;
        return res;
    endfunction

    function automatic request_t random_request();
        request_t rq;
        int unsigned pick, size;
        size = eff_columns() * eff_rows();
        rq.mode      = MODE_W'($urandom_range(3));
        rq.character = CHAR_W'($urandom_range(255));
        rq.column_x  = COORD_W'($urandom_range(255));
        rq.row_y     = COORD_W'($urandom_range(255));
        rq.position  = POS_W'($urandom_range(8191));
        pick = $urandom_range(99);
        if (pick < 62) rq.mode = MODE_PUT;
        else if (pick < 79) rq.mode = MODE_LOCATE;
        else if (pick < 95) rq.mode = MODE_SET;
        else rq.mode = MODE_UNUSED;
        if (rq.mode == MODE_PUT && $urandom_range(99) < 35)
            rq.character = CHAR_W'($urandom_range(CH_RETURN, CH_BELL));
        if ($urandom_range(1)) begin
            rq.column_x = COORD_W'($urandom_range(eff_columns() - 1));
            rq.row_y    = COORD_W'($urandom_range(eff_rows() - 1));
        end
        if ($urandom_range(1)) rq.position = POS_W'($urandom_range(size - 1));
        return rq;
    endfunction

    function automatic request_t make_req(logic [MODE_W-1:0] mode, int unsigned ch,
                                          int unsigned x, int unsigned y, int unsigned pos);
        request_t rq;
        rq.mode      = mode;
        rq.character = CHAR_W'(ch);
        rq.column_x  = COORD_W'(x);
        rq.row_y     = COORD_W'(y);
        rq.position  = POS_W'(pos);
        return rq;
    endfunction

    task automatic queue_req(request_t rq);
        pending_reqs.push_back(rq);
        queued_count++;
    endtask

    task automatic wait_drained();
        while (accepted_count != queued_count || expected_cells.size() != 0)
            @(posedge aclk);
    endtask

    // Leaves cfg_valid high on return so that writes can follow back to back.
    task automatic write_register(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        cfg_index <= idx;
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        write_beats++;
        case (idx)
            REG_COLUMNS:   cols_shadow = value;
            REG_ROWS:      rows_shadow = value[ROWS_CFG_W-1:0];
            REG_ATTRIBUTE: attr_shadow = value;
            default: ;
        endcase
    endtask

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            fail_count++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endfunction

    // Sender: presents queued requests, holding each until its beat is taken.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                expected_cells.push_back(predict_cell(offered_req));
                accepted_count++;
            end
            if (!s_tvalid || s_tready) begin
                if (pending_reqs.size() != 0 &&
                    !(idle_enable && $urandom_range(99) < IDLE_PERCENT)) begin
                    offered_req = pending_reqs.pop_front();
                    s_tdata  <= {3'b000, offered_req.position, offered_req.row_y,
                                 offered_req.column_x, offered_req.character};
                    s_tuser  <= offered_req.mode;
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Long receiver hold-off, started on request from the stimulus process.
    always @(posedge aclk) begin
        if (hold_requests != hold_served) begin
            rx_hold_left <= HOLD_CYCLES;
            hold_served  <= hold_requests;
        end else if (rx_hold_left != 0) begin
            rx_hold_left <= rx_hold_left - 1;
        end
    end

    // Receiver: checks every result beat against the oldest prediction.
    always @(posedge aclk) begin
        cell_result_t got, want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got.write_valid     = m_tuser;
                got.write_address   = m_tdata[12:0];
                got.write_character = m_tdata[20:13];
                got.write_attribute = m_tdata[28:21];
                got.scroll          = m_tdata[29];
                got.cursor          = m_tdata[42:30];
                result_count++;
                if (expected_cells.size() == 0) begin
                    fail_count++;
                    $display("%0t: result beat with nothing expected, cursor %0d",
                             $time, got.cursor);
                end else begin
                    want = expected_cells.pop_front();
                    check_field("write_valid", want.write_valid, got.write_valid);
                    check_field("write_address", want.write_address, got.write_address);
                    check_field("write_character", want.write_character,
                                got.write_character);
                    check_field("write_attribute", want.write_attribute,
                                got.write_attribute);
                    check_field("scroll", want.scroll, got.scroll);
                    check_field("cursor", want.cursor, got.cursor);
                end
            end
            m_tready <= !(rx_hold_left != 0 ||
                          (idle_enable && $urandom_range(99) < IDLE_PERCENT));
        end
    end

    initial begin
        #20000000;
        $display("text_console_cursor_engine regression: fail");
        $finish;
    end

    initial begin
        int unsigned cols_value, rows_value;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed requests on the reset geometry of 80 by 25 cells.
        queue_req(make_req(MODE_PUT, 65, 0, 0, 0));
        queue_req(make_req(MODE_PUT, 0, 255, 255, 8191));
        queue_req(make_req(MODE_PUT, 255, 0, 0, 0));
        queue_req(make_req(MODE_PUT, CH_NEWLINE, 17, 3, 100));
        queue_req(make_req(MODE_PUT, CH_TAB, 0, 0, 0));
        queue_req(make_req(MODE_PUT, CH_BACKSPACE, 0, 0, 0));
        queue_req(make_req(MODE_PUT, CH_RETURN, 0, 0, 0));
        queue_req(make_req(MODE_PUT, CH_VTAB, 0, 0, 0));
        queue_req(make_req(MODE_PUT, CH_BELL, 0, 0, 0));
        queue_req(make_req(MODE_PUT, CH_FORMFEED, 0, 0, 0));
        queue_req(make_req(MODE_PUT, CH_BACKSPACE, 0, 0, 0));
        queue_req(make_req(MODE_SET, 0, 0, 0, 8191));
        queue_req(make_req(MODE_PUT, 90, 0, 0, 0));
        queue_req(make_req(MODE_SET, 0, 0, 0, 1999));
        queue_req(make_req(MODE_PUT, CH_TAB, 0, 0, 0));
        queue_req(make_req(MODE_SET, 0, 0, 0, 1990));
        queue_req(make_req(MODE_PUT, CH_NEWLINE, 0, 0, 0));
        queue_req(make_req(MODE_PUT, CH_VTAB, 0, 0, 0));
        queue_req(make_req(MODE_LOCATE, 0, 255, 255, 0));
        queue_req(make_req(MODE_LOCATE, 0, 0, 0, 8191));
        queue_req(make_req(MODE_LOCATE, 0, 79, 24, 0));
        queue_req(make_req(MODE_SET, 255, 255, 255, 0));
        queue_req(make_req(MODE_UNUSED, 255, 255, 255, 8191));
        queue_req(make_req(MODE_SET, 0, 0, 0, 1999));
        queue_req(make_req(MODE_PUT, 120, 255, 255, 8191));
        wait_drained();

        for (int phase = 0; phase < 11; phase++) begin
            case (phase)
                0: begin cols_value = 1;   rows_value = 1;   end
                1: begin cols_value = 128; rows_value = 64;  end
                2: begin cols_value = 0;   rows_value = 0;   end
                3: begin cols_value = 255; rows_value = 127; end
                4: begin cols_value = 3;   rows_value = 2;   end
                5: begin cols_value = 8;   rows_value = 4;   end
                default: begin
                    cols_value = $urandom_range(1) ? $urandom_range(255) : $urandom_range(1, 16);
                    rows_value = $urandom_range(1) ? $urandom_range(127) : $urandom_range(1, 8);
                end
            endcase
            write_register(REG_COLUMNS, CFG_DATA_W'(cols_value));
            write_register(REG_ROWS, CFG_DATA_W'(rows_value));
            write_register(REG_ATTRIBUTE, (phase == 0) ? 8'd0 :
                           (phase == 1) ? 8'd255 : CFG_DATA_W'($urandom_range(255)));
            cfg_valid <= 1'b0;
            idle_enable = (phase != 4);
            if (phase == 2) hold_requests++;
            // The previous phase parked the cursor on its last cell (the directed requests leave it at
            // the start of the last line), which may now be beyond a smaller screen.
            queue_req(make_req(MODE_PUT, $urandom_range(32, 255), 0, 0, 0));
            repeat (58) queue_req(random_request());
            queue_req(make_req(MODE_SET, 0, 0, 0, 8191));
            wait_drained();
        end

        repeat (40) @(posedge aclk);
        $display("Covered %0d requests and %0d result beats over 12 screen settings,",
                 accepted_count, result_count);
        $display("with %0d register writes, random stalls and one long receiver hold-off.",
                 write_beats);
        if (fail_count == 0) begin
            $display("text_console_cursor_engine regression: pass");
        end else begin
            $display("text_console_cursor_engine regression: fail");
        end
        $finish;
    end

endmodule
